[hdl/pot_normalize_smooth_unit_assert.svh]
// Assertion macros for the checker file of the potentiometer filter.
`ifndef POT_NORMALIZE_SMOOTH_UNIT_ASSERT_SVH
`define POT_NORMALIZE_SMOOTH_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PNS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PNS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/pns_pkg.sv]
// Shared types, constants and the saturation function of the potentiometer filter.
package pns_pkg;

   localparam int RAW_W  = 12;
   localparam int Q_W    = 18;
   localparam int COEF_W = 16;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_MIN_RAW   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_RAW   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SMOOTHING = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL   = 2'd3;

   localparam logic [RAW_W-1:0]  MIN_RAW_RESET   = 12'd0;
   localparam logic [RAW_W-1:0]  MAX_RAW_RESET   = 12'd4095;
   localparam logic [COEF_W-1:0] SMOOTHING_RESET = 16'd0;

   // Coefficients at or above one half select the moving average.
   localparam logic [COEF_W-1:0] HALF_COEF = 16'd32768;

   // Serial divider: magnitude dividend, magnitude divisor, two bits a cycle.
   localparam int DIV_DW     = 28;
   localparam int DIV_VW     = 12;
   localparam int DIV_QW     = DIV_DW + 1;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_ITER   = DIV_DW / DIV_STEPS;
   localparam int DIV_CNT_W  = $clog2(DIV_ITER);

   localparam logic signed [DIV_QW-1:0] Q_MAX_X = 29'sd131071;
   localparam logic signed [DIV_QW-1:0] Q_MIN_X = -29'sd131072;
   localparam logic signed [Q_W-1:0]    Q_MAX_Q = 18'sd131071;
   localparam logic signed [Q_W-1:0]    Q_MIN_Q = -18'sd131072;

   typedef struct packed {
      logic              start;
      logic [DIV_DW-1:0] dividend;
      logic [DIV_VW-1:0] divisor;
      logic              negate;
   } div_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [DIV_QW-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic                  start;
      logic signed [Q_W-1:0] value;
   } ring_req_type;

   // Clamp a wide signed value to the Q2.16 range.
   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [DIV_QW-1:0] x);
      logic signed [Q_W-1:0] r;
      if (x > Q_MAX_X) begin
         r = Q_MAX_Q;
      end else if (x < Q_MIN_X) begin
         r = Q_MIN_Q;
      end else begin
         r = signed'(x[Q_W-1:0]);
      end
      return r;
   endfunction

endpackage

[hdl/pns_if.sv]
// Valid/ready channel interfaces for the sample and result transfers.
interface pns_req_if;
   import pns_pkg::*;
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] raw_sample;
   modport source (output valid, output raw_sample, input ready);
   modport sink (input valid, input raw_sample, output ready);
endinterface

interface pns_rsp_if;
   import pns_pkg::*;
   logic                  valid;
   logic                  ready;
   logic signed [Q_W-1:0] filtered_value;
   logic signed [Q_W-1:0] normalized_value;
   logic                  range_error;
   modport source (output valid, output filtered_value, output normalized_value,
                   output range_error, input ready);
   modport sink (input valid, input filtered_value, input normalized_value,
                 input range_error, output ready);
endinterface

[hdl/pot_normalize_smooth_unit.sv]
// Top level of the potentiometer normalizing and smoothing filter.
//
//   Channel   Direction  Handshake          Payload
//   req_bus   in         valid/ready        raw_sample (12b unsigned)
//   rsp_bus   out        valid/ready        filtered_value, normalized_value (18b Q2.16),
//                                           range_error (1b)
//   csr_*     in         csr_we, no stall   csr_index (2b), csr_wdata (16b)
//
// A sample occupies the unit from its transfer until FINISH hands its result to the output
// register and the sequencer returns to IDLE. IDLE goes straight to FINISH when the channel
// is off or the range is empty; pass-through runs NORM, exponential smoothing runs NORM,
// EXP_MUL and EXP_ADD, and the moving average runs NORM, RING, RING_SUM, AVG_GO and AVG.
// The shared serial divider sets the length of NORM and AVG; the moving average needs it twice.
// Reset is synchronous and clears the ring, its sum, slot, fill count and smoothed value.
// A new sample is taken as soon as the sequencer is idle, even while a result waits in the
// output register; a stalled result only holds the final step of the following sample.
module pot_normalize_smooth_unit #(
   parameter int WINDOW = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   pns_req_if.sink                           req_bus,
   pns_rsp_if.source                         rsp_bus,
   input  logic                              csr_we,
   input  logic [pns_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pns_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pns_pkg::*;

   localparam int SUM_W  = Q_W + $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int PROD_W = Q_W + 1 + COEF_W + 1;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

   // One-hot sequencer states.
   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_NORM     = 9'b000000010,
      ST_EXP_MUL  = 9'b000000100,
      ST_EXP_ADD  = 9'b000001000,
      ST_RING     = 9'b000010000,
      ST_RING_SUM = 9'b000100000,
      ST_AVG_GO   = 9'b001000000,
      ST_AVG      = 9'b010000000,
      ST_FINISH   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [RAW_W-1:0]  min_raw_ff, min_raw_in;
   logic [RAW_W-1:0]  max_raw_ff, max_raw_in;
   logic [COEF_W-1:0] smoothing_ff, smoothing_in;
   logic              enabled_ff, enabled_in;

   // Datapath registers.
   logic signed [Q_W-1:0]    value_ff, value_in;
   logic signed [Q_W-1:0]    smoothed_ff, smoothed_in;
   logic signed [PROD_W-1:0] mul_ff, mul_in;
   logic signed [Q_W-1:0]    res_filt_ff, res_filt_in;
   logic signed [Q_W-1:0]    res_norm_ff, res_norm_in;
   logic                     res_err_ff, res_err_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [Q_W-1:0] rsp_filt_ff, rsp_filt_in;
   logic signed [Q_W-1:0] rsp_norm_ff, rsp_norm_in;
   logic                  rsp_err_ff, rsp_err_in;

   div_req_type  div_req;
   div_rsp_type  div_rsp;
   ring_req_type ring_req;
   logic signed [SUM_W-1:0] ring_sum;
   logic [FILL_W-1:0]       ring_fill;

   logic                      req_xfer;
   logic signed [RAW_W:0]     num_s;
   logic signed [RAW_W:0]     den_s;
   logic [RAW_W:0]            num_mag;
   logic [RAW_W:0]            den_mag;
   logic signed [DIV_DW:0]    sum_x;
   logic [DIV_DW:0]           sum_mag;
   logic signed [Q_W:0]       diff_s;
   logic signed [PROD_W-1:0]  exp_sh;
   logic signed [DIV_QW-1:0]  exp_sum;
   logic signed [Q_W-1:0]     quo_sat;

   pns_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   pns_ring #(.WINDOW(WINDOW)) u_ring (
      .clock     (clock),
      .reset     (reset),
      .ring_req  (ring_req),
      .ring_sum  (ring_sum),
      .ring_fill (ring_fill)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;

   // Signed numerator and denominator of the normalization, split into sign and
   // magnitude for the divider. A reversed range gives a negative denominator.
   assign num_s   = signed'({1'b0, req_bus.raw_sample}) - signed'({1'b0, min_raw_ff});
   assign den_s   = signed'({1'b0, max_raw_ff}) - signed'({1'b0, min_raw_ff});
   assign num_mag = num_s[RAW_W] ? -num_s : num_s;
   assign den_mag = den_s[RAW_W] ? -den_s : den_s;

   // Magnitude of the ring sum for the average division.
   assign sum_x   = (DIV_DW + 1)'(ring_sum);
   assign sum_mag = sum_x[DIV_DW] ? -sum_x : sum_x;

   // Exponential smoothing is written as prev + (value - prev) * s, rounded half up,
   // which needs only one multiply.
   assign diff_s  = (Q_W + 1)'(value_ff) - (Q_W + 1)'(smoothed_ff);
   assign exp_sh  = (mul_ff + ROUND_HALF) >>> 16;
   assign exp_sum = DIV_QW'(exp_sh) + DIV_QW'(smoothed_ff);

   assign quo_sat = sat_q(div_rsp.quotient);

   // Configuration writes.
   always_comb begin
      min_raw_in   = min_raw_ff;
      max_raw_in   = max_raw_ff;
      smoothing_in = smoothing_ff;
      enabled_in   = enabled_ff;
      if (csr_we) begin
         case (csr_index)
            REG_MIN_RAW:   min_raw_in   = csr_wdata[RAW_W-1:0];
            REG_MAX_RAW:   max_raw_in   = csr_wdata[RAW_W-1:0];
            REG_SMOOTHING: smoothing_in = csr_wdata[COEF_W-1:0];
            REG_CHANNEL:   enabled_in   = csr_wdata[0];
            default:       enabled_in   = enabled_ff;
         endcase
      end
   end

   // Sequencer and datapath.
   always_comb begin
      state_in    = state_ff;
      value_in    = value_ff;
      smoothed_in = smoothed_ff;
      mul_in      = mul_ff;
      res_filt_in = res_filt_ff;
      res_norm_in = res_norm_ff;
      res_err_in  = res_err_ff;

      div_req.start    = 1'b0;
      div_req.dividend = {num_mag[RAW_W-1:0], 16'b0};
      div_req.divisor  = den_mag[RAW_W-1:0];
      div_req.negate   = num_s[RAW_W] ^ den_s[RAW_W];

      ring_req.start = 1'b0;
      ring_req.value = value_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_filt_in  = rsp_filt_ff;
      rsp_norm_in  = rsp_norm_ff;
      rsp_err_in   = rsp_err_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               res_filt_in = '0;
               res_norm_in = '0;
               res_err_in  = 1'b0;
               if (!enabled_ff) begin
                  state_in = ST_FINISH;
               end else if (min_raw_ff == max_raw_ff) begin
                  res_err_in = 1'b1;
                  state_in   = ST_FINISH;
               end else begin
                  div_req.start = 1'b1;
                  state_in      = ST_NORM;
               end
            end
         end
         ST_NORM: begin
            if (div_rsp.done) begin
               value_in    = quo_sat;
               res_norm_in = quo_sat;
               if (smoothing_ff == '0) begin
                  res_filt_in = quo_sat;
                  smoothed_in = quo_sat;
                  state_in    = ST_FINISH;
               end else if (smoothing_ff < HALF_COEF) begin
                  state_in = ST_EXP_MUL;
               end else begin
                  state_in = ST_RING;
               end
            end
         end
         ST_EXP_MUL: begin
            mul_in   = diff_s * signed'({1'b0, smoothing_ff});
            state_in = ST_EXP_ADD;
         end
         ST_EXP_ADD: begin
            res_filt_in = sat_q(exp_sum);
            smoothed_in = sat_q(exp_sum);
            state_in    = ST_FINISH;
         end
         ST_RING: begin
            ring_req.start = 1'b1;
            state_in       = ST_RING_SUM;
         end
         ST_RING_SUM: begin
            // The ring folds the new sample into its sum during this cycle.
            state_in = ST_AVG_GO;
         end
         ST_AVG_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = sum_mag[DIV_DW-1:0];
            div_req.divisor  = DIV_VW'(ring_fill);
            div_req.negate   = sum_x[DIV_DW];
            state_in         = ST_AVG;
         end
         ST_AVG: begin
            if (div_rsp.done) begin
               res_filt_in = quo_sat;
               smoothed_in = quo_sat;
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hand the result over once the output register is free or being emptied.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_filt_in  = res_filt_ff;
               rsp_norm_in  = res_norm_ff;
               rsp_err_in   = res_err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_raw_ff   <= MIN_RAW_RESET;
         max_raw_ff   <= MAX_RAW_RESET;
         smoothing_ff <= SMOOTHING_RESET;
         enabled_ff   <= 1'b1;
         smoothed_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_raw_ff   <= min_raw_in;
         max_raw_ff   <= max_raw_in;
         smoothing_ff <= smoothing_in;
         enabled_ff   <= enabled_in;
         smoothed_ff  <= smoothed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff    <= value_in;
      mul_ff      <= mul_in;
      res_filt_ff <= res_filt_in;
      res_norm_ff <= res_norm_in;
      res_err_ff  <= res_err_in;
      rsp_filt_ff <= rsp_filt_in;
      rsp_norm_ff <= rsp_norm_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.filtered_value   = rsp_filt_ff;
   assign rsp_bus.normalized_value = rsp_norm_ff;
   assign rsp_bus.range_error      = rsp_err_ff;

endmodule

[hdl/pns_divider.sv]
// Shared serial restoring divider with sign correction, two quotient bits a cycle.
module pns_divider (
   input  logic                clock,
   input  logic                reset,
   input  pns_pkg::div_req_type div_req,
   output pns_pkg::div_rsp_type div_rsp
);
   import pns_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIV_VW:0]      rem_ff, rem_in;
   logic [DIV_DW-1:0]    quo_ff, quo_in;
   logic [DIV_VW-1:0]    dvs_ff, dvs_in;
   logic                 neg_ff, neg_in;
   logic signed [DIV_QW-1:0] quo_ext;

   always_comb begin
      logic [DIV_VW:0]   r;
      logic [DIV_VW:0]   t;
      logic [DIV_DW-1:0] q;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      neg_in   = neg_ff;
      r        = rem_ff;
      q        = quo_ff;
      t        = '0;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = div_req.dividend;
         dvs_in   = div_req.divisor;
         neg_in   = div_req.negate;
      end else if (busy_ff) begin
         for (int i = 0; i < DIV_STEPS; i++) begin
            t = {r[DIV_VW-1:0], q[DIV_DW-1]};
            q = {q[DIV_DW-2:0], 1'b0};
            if (t >= {1'b0, dvs_ff}) begin
               t    = t - {1'b0, dvs_ff};
               q[0] = 1'b1;
            end
            r = t;
         end
         rem_in   = r;
         quo_in   = q;
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(DIV_ITER - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign quo_ext          = signed'({1'b0, quo_ff});
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? -quo_ext : quo_ext;

endmodule

[hdl/pns_ring.sv]
// Moving-average ring: sample memory, running sum, write slot and fill count.
module pns_ring #(
   parameter int WINDOW = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pns_pkg::ring_req_type ring_req,
   output logic signed [pns_pkg::Q_W+$clog2(WINDOW)-1:0] ring_sum,
   output logic [$clog2(WINDOW+1)-1:0]                   ring_fill
);
   import pns_pkg::*;

   localparam int SUM_W  = Q_W + $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   logic signed [Q_W-1:0] mem [WINDOW];
   logic signed [Q_W-1:0] rd_ff;
   logic signed [Q_W-1:0] val_ff;
   logic                  pend_ff, pend_in;
   logic                  full_ff, full_in;
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [SUM_W-1:0] old_ext;

   // Slots are written in order from zero, so a slot holds data only once
   // the ring has filled; before that the old entry reads as zero.
   assign old_ext = full_ff ? SUM_W'(rd_ff) : '0;

   always_comb begin
      pend_in = ring_req.start;
      full_in = full_ff;
      slot_in = slot_ff;
      fill_in = fill_ff;
      sum_in  = sum_ff;
      if (ring_req.start) begin
         full_in = (fill_ff == FILL_W'(WINDOW));
      end
      if (pend_ff) begin
         sum_in  = sum_ff + SUM_W'(val_ff) - old_ext;
         slot_in = (slot_ff == IDX_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
         if (fill_ff != FILL_W'(WINDOW)) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ring_req.start) begin
         mem[slot_ff] <= ring_req.value;
         rd_ff        <= mem[slot_ff];
         val_ff       <= ring_req.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         full_ff <= 1'b0;
         slot_ff <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
      end else begin
         pend_ff <= pend_in;
         full_ff <= full_in;
         slot_ff <= slot_in;
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
      end
   end

   assign ring_sum  = sum_ff;
   assign ring_fill = fill_ff;

endmodule

[hdl/pns_checker.sv]
// Port-level checker of the potentiometer filter and its bind to the top level.
`include "pot_normalize_smooth_unit_assert.svh"

module pns_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [17:0] rsp_filtered_value,
   input logic [17:0] rsp_normalized_value,
   input logic        rsp_range_error
);

   // A waiting result keeps its payload until it is taken.
   `PNS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_filtered_value) && $stable(rsp_normalized_value)
         && $stable(rsp_range_error),
      "result changed while stalled")

   // An empty range never carries a value.
   `PNS_ASSERT_SAME(a_err_zero, clock, reset, rsp_valid && rsp_range_error,
      rsp_filtered_value == 18'd0 && rsp_normalized_value == 18'd0,
      "range error with nonzero value")

   // The block works on one sample at a time.
   `PNS_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready,
      "sample taken while busy")

   // A result is never registered at the same edge that takes its sample.
   `PNS_ASSERT_SAME(a_latency, clock, reset, $rose(rsp_valid),
      !$past(req_valid && req_ready), "result appeared too early")

endmodule

bind pot_normalize_smooth_unit pns_checker u_pns_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_bus.valid),
   .req_ready            (req_bus.ready),
   .rsp_valid            (rsp_bus.valid),
   .rsp_ready            (rsp_bus.ready),
   .rsp_filtered_value   (rsp_bus.filtered_value),
   .rsp_normalized_value (rsp_bus.normalized_value),
   .rsp_range_error      (rsp_bus.range_error)
);
